// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_RST_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_RST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication through reset");

`endif

// ===== sv/esd_pkg.sv =====
// Shared types, constants and decode functions for the escape sequence decoder.
`default_nettype none

package esd_pkg;

    // Reset value of the escape byte (asterisk).
    localparam logic [7:0] ESC_RESET = 8'h2a;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Letters that select a code, lower case.
    localparam logic [7:0] LTR_N = 8'h6e;
    localparam logic [7:0] LTR_T = 8'h74;
    localparam logic [7:0] LTR_V = 8'h76;
    localparam logic [7:0] LTR_B = 8'h62;
    localparam logic [7:0] LTR_R = 8'h72;
    localparam logic [7:0] LTR_F = 8'h66;
    localparam logic [7:0] LTR_E = 8'h65;
    localparam logic [7:0] LTR_X = 8'h78;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Control codes the letters map to.
    localparam logic [7:0] CODE_NEWLINE   = 8'h0a;
    localparam logic [7:0] CODE_TAB       = 8'h09;
    localparam logic [7:0] CODE_VTAB      = 8'h0b;
    localparam logic [7:0] CODE_BACKSPACE = 8'h08;
    localparam logic [7:0] CODE_RETURN    = 8'h0d;
    localparam logic [7:0] CODE_FORMFEED  = 8'h0c;
    localparam logic [7:0] CODE_ESCAPE    = 8'h1b;

    // Offsets of the unchecked digit conversion.
    localparam logic [7:0] OFS_LOWER = 8'd87;
    localparam logic [7:0] OFS_UPPER = 8'd55;
    localparam logic [7:0] OFS_DIGIT = 8'd48;
    localparam logic [7:0] CHR_LOWER_A = 8'd97;
    localparam logic [7:0] CHR_UPPER_A = 8'd65;

    // Parser state, one-hot.
    typedef enum logic [3:0] {
        MD_NORMAL = 4'b0001,
        MD_ESC    = 4'b0010,
        MD_HEX1   = 4'b0100,
        MD_HEX2   = 4'b1000
    } t_parse_mode;

    // Back-end emit state, one-hot.
    typedef enum logic [1:0] {
        BK_FIRST  = 2'b01,
        BK_SECOND = 2'b10
    } t_back_state;

    // Work for the back end from one input transaction.
    typedef struct packed {
        logic       a_valid;
        logic [7:0] a_byte;
        logic       b_valid;
        logic [7:0] b_byte;
        logic       last;
    } t_esd_entry;

    // Result of the letter lookup after an escape.
    typedef struct packed {
        logic       is_x;
        logic [7:0] code;
    } t_code_res;

    // Digit conversion without a validity check; wraps modulo 256.
    function automatic logic [7:0] unchecked_hex(input logic [7:0] c);
        logic [7:0] r;
        if (c >= CHR_LOWER_A) begin
            r = c - OFS_LOWER;
        end else if (c >= CHR_UPPER_A) begin
            r = c - OFS_UPPER;
        end else begin
            r = c - OFS_DIGIT;
        end
        return r;
    endfunction

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Map the byte after an escape to its code; other bytes pass unchanged.
    function automatic t_code_res code_for(input logic [7:0] c);
        t_code_res r;
        r.is_x = 1'b0;
        r.code = c;
        case (c | CASE_BIT)
            LTR_N: r.code = CODE_NEWLINE;
            LTR_T: r.code = CODE_TAB;
            LTR_V: r.code = CODE_VTAB;
            LTR_B: r.code = CODE_BACKSPACE;
            LTR_R: r.code = CODE_RETURN;
            LTR_F: r.code = CODE_FORMFEED;
            LTR_E: r.code = CODE_ESCAPE;
            LTR_X: begin
                r.is_x = 1'b1;
                r.code = 8'h00;
            end
            default: r.code = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/escape_sequence_decoder_core.sv =====
// The first result of an input transaction passes through the queue and then the
// back-end result register before it is offered.
// One input byte per cycle while the queue is not full; a step that emits two bytes
// holds the back end in its second emit state; the input stalls when the queue fills.
// Reset is synchronous and active low: parser, queue and count clear, and the
// escape byte returns to an asterisk.
`default_nettype none

module escape_sequence_decoder_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_valid,
    output logic             o_out_last,
    output logic [15:0]      o_decoded_length
);

    logic                w_push;
    logic                w_full;
    logic                w_q_valid;
    logic                w_pop;
    esd_pkg::t_esd_entry w_push_entry;
    esd_pkg::t_esd_entry w_q_entry;

    // Parser front end.
    esd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // Decoupling queue.
    esd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    // Emit back end.
    esd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_entry        (w_q_entry),
        .o_q_pop          (w_pop),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_out_byte       (o_out_byte),
        .o_out_valid      (o_out_valid),
        .o_out_last       (o_out_last),
        .o_decoded_length (o_decoded_length)
    );

endmodule

`default_nettype wire

// ===== sv/esd_front.sv =====
// Front end: accepts input transactions, runs the escape parser and queues its emits.
`default_nettype none

module esd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_in_last,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output esd_pkg::t_esd_entry    o_entry
);

    logic [7:0]           r_esc;
    esd_pkg::t_parse_mode r_mode;
    esd_pkg::t_parse_mode n_mode;
    logic [7:0]           r_held;
    logic [7:0]           n_held;
    esd_pkg::t_esd_entry  w_ent;
    esd_pkg::t_code_res   w_code;
    logic                 w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_code     = esd_pkg::code_for(i_in_byte);

    // Parser step for the byte on the input.
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        w_ent  = '0;
        case (r_mode)
            esd_pkg::MD_NORMAL: begin
                if (i_in_byte == r_esc) begin
                    n_mode = esd_pkg::MD_ESC;
                end else begin
                    w_ent.a_valid = 1'b1;
                    w_ent.a_byte  = i_in_byte;
                end
            end
            esd_pkg::MD_ESC: begin
                if (w_code.is_x) begin
                    n_mode = esd_pkg::MD_HEX1;
                end else begin
                    n_mode        = esd_pkg::MD_NORMAL;
                    w_ent.a_valid = 1'b1;
                    w_ent.a_byte  = w_code.code;
                end
            end
            esd_pkg::MD_HEX1: begin
                n_held        = esd_pkg::unchecked_hex(i_in_byte);
                n_mode        = esd_pkg::MD_HEX2;
                w_ent.a_valid = i_in_last;
                w_ent.a_byte  = n_held;
            end
            esd_pkg::MD_HEX2: begin
                n_mode        = esd_pkg::MD_NORMAL;
                w_ent.a_valid = 1'b1;
                if (esd_pkg::is_hex(i_in_byte)) begin
                    w_ent.a_byte = {r_held[3:0], 4'b0000} +
                                   esd_pkg::unchecked_hex(i_in_byte);
                end else begin
                    // The held digit goes out alone and the byte starts over.
                    w_ent.a_byte = r_held;
                    if (i_in_byte == r_esc) begin
                        n_mode = esd_pkg::MD_ESC;
                    end else begin
                        w_ent.b_valid = 1'b1;
                        w_ent.b_byte  = i_in_byte;
                    end
                end
            end
            default: begin
                n_mode = esd_pkg::MD_NORMAL;
            end
        endcase
        // A string end always returns the parser to normal.
        if (i_in_last) begin
            n_mode = esd_pkg::MD_NORMAL;
        end
        w_ent.last = i_in_last;
    end

    // Only transactions that emit something or end a string reach the queue.
    assign o_push  = w_accept && (w_ent.a_valid || i_in_last);
    assign o_entry = w_ent;

    // Parser state and escape register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= esd_pkg::ESC_RESET;
            r_mode <= esd_pkg::MD_NORMAL;
            r_held <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_esc <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_mode <= n_mode;
                r_held <= n_held;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/esd_fifo.sv =====
// Short queue of parser entries between the front and the back.
`default_nettype none

module esd_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire esd_pkg::t_esd_entry i_entry,
    output logic                     o_full,
    output logic                     o_valid,
    output esd_pkg::t_esd_entry      o_entry,
    input  wire logic                i_pop
);

    localparam int Depth = esd_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    esd_pkg::t_esd_entry r_mem [Depth];
    logic [PtrW-1:0]     r_wptr;
    logic [PtrW-1:0]     r_rptr;
    logic [CntW-1:0]     r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/esd_back.sv =====
// Back end: drains queued entries into result transactions and keeps the length count.
`default_nettype none

module esd_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire esd_pkg::t_esd_entry i_q_entry,
    output logic                     o_q_pop,
    output logic                     o_res_valid,
    input  wire logic                i_res_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_out_valid,
    output logic                     o_out_last,
    output logic [15:0]              o_decoded_length
);

    esd_pkg::t_back_state   r_state;
    logic                   r_res_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_valid;
    logic                   r_out_last;
    logic [15:0]            r_len;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [7:0]             r_b_byte;
    logic                   r_b_last;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_load;

    // Saturating count after one more decoded byte.
    assign w_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign w_load = !r_res_valid || i_res_ready;
    assign o_q_pop = w_load && (r_state == esd_pkg::BK_FIRST) && i_q_valid;

    assign o_res_valid      = r_res_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_valid      = r_out_valid;
    assign o_out_last       = r_out_last;
    assign o_decoded_length = r_len;

    // Control: handshake valid, emit state and length count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esd_pkg::BK_FIRST;
            r_res_valid <= 1'b0;
            r_count     <= '0;
        end else if (w_load) begin
            case (r_state)
                esd_pkg::BK_SECOND: begin
                    r_res_valid <= 1'b1;
                    r_state     <= esd_pkg::BK_FIRST;
                    r_count     <= r_b_last ? '0 : w_inc;
                end
                esd_pkg::BK_FIRST: begin
                    r_res_valid <= i_q_valid;
                    if (i_q_valid) begin
                        if (i_q_entry.b_valid) begin
                            r_state <= esd_pkg::BK_SECOND;
                            r_count <= w_inc;
                        end else if (i_q_entry.a_valid) begin
                            r_count <= i_q_entry.last ? '0 : w_inc;
                        end else begin
                            r_count <= '0;
                        end
                    end
                end
                default: begin
                    r_state     <= esd_pkg::BK_FIRST;
                    r_res_valid <= 1'b0;
                end
            endcase
        end
    end

    // Result payload and the pending second byte.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == esd_pkg::BK_SECOND) begin
                r_out_byte  <= r_b_byte;
                r_out_valid <= 1'b1;
                r_out_last  <= r_b_last;
                r_len       <= 16'(w_inc);
            end else if (i_q_valid) begin
                r_b_byte <= i_q_entry.b_byte;
                r_b_last <= i_q_entry.last;
                if (i_q_entry.a_valid) begin
                    r_out_byte  <= i_q_entry.a_byte;
                    r_out_valid <= 1'b1;
                    r_out_last  <= i_q_entry.last && !i_q_entry.b_valid;
                    r_len       <= 16'(w_inc);
                end else begin
                    // End of string with nothing to emit.
                    r_out_byte  <= 8'h00;
                    r_out_valid <= 1'b0;
                    r_out_last  <= 1'b1;
                    r_len       <= 16'(r_count);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module esd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_res_ready,
    input wire logic        o_res_valid,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_out_valid,
    input wire logic        o_out_last,
    input wire logic [15:0] o_decoded_length
);

    // A stalled result transaction keeps its payload.
    `ASSERT_RST_NEXT(a_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_out_byte) && $stable(o_out_last) && $stable(o_decoded_length))

    // A result without a byte only marks a string end and carries a zero byte.
    `ASSERT_RST_IMPLIES(a_empty_last, i_clk, i_rst_n, o_res_valid && !o_out_valid, o_out_last && (o_out_byte == 8'h00))

    // The byte right after a string end starts the count again at one.
    `ASSERT_RST_NEXT(a_count_restart, i_clk, i_rst_n, o_res_valid && i_res_ready && o_out_last, !o_res_valid || !o_out_valid || (o_decoded_length == 16'd1))

    // No result is offered right after reset.
    `ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_res_valid)

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);

`default_nettype wire
